/* hdl/vlt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlt_pkg
// Shared types, constants and the crossing-time compare for the voxel walk.
// ----------------------------------------------------------------------------
package vlt_pkg;

    localparam int COORD_BITS = 4;
    localparam int COORD_W    = 4;
    localparam int PROD_W     = 2 * COORD_BITS + 1;
    localparam int MAX_STEPS  = 3 * ((1 << COORD_BITS) - 1);
    localparam int CNT_W      = $clog2(MAX_STEPS + 1);
    localparam int Q_AW       = 1;
    localparam int Q_DEPTH    = 1 << Q_AW;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord [2:0] pos;
        t_coord [2:0] fin;
        t_coord [2:0] delta;
        logic   [2:0] up;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // true when axis a crosses strictly before axis b; zero distance never crosses
    function automatic logic earlier(input t_coord ka, input t_coord da,
                                     input t_coord kb, input t_coord db);
        logic [PROD_W-1:0] pa;
        logic [PROD_W-1:0] pb;
        pa = PROD_W'({ka, 1'b1}) * PROD_W'(db);
        pb = PROD_W'({kb, 1'b1}) * PROD_W'(da);
        if (da == '0) begin
            earlier = 1'b0;
        end else if (db == '0) begin
            earlier = 1'b1;
        end else begin
            earlier = (pa < pb);
        end
    endfunction

endpackage

/* hdl/vlt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlt_front
// Accepts a request, masks coordinates, derives direction and distance per
// axis and drops requests whose start equals the end.
// ----------------------------------------------------------------------------
module vlt_front
    import vlt_pkg::*;
(
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_start_z,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic [COORD_W-1:0] i_end_z,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output t_job               o_job
);

    logic same;

    always_comb begin
        o_job.pos[AX_X] = i_start_x[COORD_BITS-1:0];
        o_job.pos[AX_Y] = i_start_y[COORD_BITS-1:0];
        o_job.pos[AX_Z] = i_start_z[COORD_BITS-1:0];
        o_job.fin[AX_X] = i_end_x[COORD_BITS-1:0];
        o_job.fin[AX_Y] = i_end_y[COORD_BITS-1:0];
        o_job.fin[AX_Z] = i_end_z[COORD_BITS-1:0];
        for (int a = 0; a < 3; a++) begin
            o_job.up[a]    = o_job.pos[a] < o_job.fin[a];
            o_job.delta[a] = o_job.up[a] ? (o_job.fin[a] - o_job.pos[a])
                                         : (o_job.pos[a] - o_job.fin[a]);
        end
        same = (o_job.pos == o_job.fin);
    end

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full && !same;

endmodule

/* hdl/vlt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlt_queue
// Small job queue between the front and the walker.
// ----------------------------------------------------------------------------
module vlt_queue
    import vlt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_job         = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/vlt_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlt_walk
// Takes one job from the queue and steps the line into an output register one
// voxel per cycle unless stalled, comparing crossing times as cross products.
// ----------------------------------------------------------------------------
module vlt_walk
    import vlt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_qstat             i_qstat,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_y,
    output logic [COORD_W-1:0] o_cell_z,
    output logic               o_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_job               r_job;
    t_coord [2:0]       r_k;
    logic   [CNT_W-1:0] r_n;
    t_coord [2:0]       r_out_pos;
    logic               r_out_last;
    logic               r_out_valid;

    t_coord [2:0]       n_pos;
    logic   [2:0]       mv;
    logic               xy;
    logic               yx;
    logic               xz;
    logic               yz;
    logic               advance;
    logic               done;
    logic               cap;

    always_comb begin
        xy = earlier(r_k[AX_X], r_job.delta[AX_X], r_k[AX_Y], r_job.delta[AX_Y]);
        yx = earlier(r_k[AX_Y], r_job.delta[AX_Y], r_k[AX_X], r_job.delta[AX_X]);
        xz = earlier(r_k[AX_X], r_job.delta[AX_X], r_k[AX_Z], r_job.delta[AX_Z]);
        yz = earlier(r_k[AX_Y], r_job.delta[AX_Y], r_k[AX_Z], r_job.delta[AX_Z]);
        if (xy) begin
            mv = xz ? 3'b001 : 3'b100;
        end else if (yx) begin
            mv = yz ? 3'b010 : 3'b100;
        end else begin
            mv = yz ? 3'b011 : 3'b100;
        end
        for (int a = 0; a < 3; a++) begin
            if (mv[a]) begin
                n_pos[a] = r_job.up[a] ? (r_job.pos[a] + 1'b1) : (r_job.pos[a] - 1'b1);
            end else begin
                n_pos[a] = r_job.pos[a];
            end
        end
        done    = (n_pos == r_job.fin);
        cap     = (r_n == CNT_W'(MAX_STEPS - 1));
        advance = (r_state == ST_RUN) && (!r_out_valid || i_ready);
    end

    assign o_pop = (r_state == ST_IDLE) && !i_qstat.empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance && (done || cap)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_k   <= '0;
            r_n   <= '0;
        end else if (advance) begin
            r_job.pos <= n_pos;
            for (int a = 0; a < 3; a++) begin
                if (mv[a]) begin
                    r_k[a] <= r_k[a] + 1'b1;
                end
            end
            r_n <= r_n + 1'b1;
        end
        if (advance) begin
            r_out_pos  <= n_pos;
            r_out_last <= done;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_cell_x = COORD_W'(r_out_pos[AX_X]);
    assign o_cell_y = COORD_W'(r_out_pos[AX_Y]);
    assign o_cell_z = COORD_W'(r_out_pos[AX_Z]);
    assign o_last   = r_out_last;

endmodule

/* hdl/voxel_line_traversal_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_line_traversal_top
// Path: request -> job queue -> walker job register -> output register.
// Throughput: one voxel per cycle from the walker's step unit while i_ready
// does not stall it, plus a job load per request; runs hold up to 45 voxels.
// A two-entry job queue lets requests be accepted while a run is emitted.
// Reset: synchronous active low, clears queue pointers, walker state and the
// output valid; no clearing pass.
// ----------------------------------------------------------------------------
module voxel_line_traversal_top
    import vlt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_start_z,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic [COORD_W-1:0] i_end_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_y,
    output logic [COORD_W-1:0] o_cell_z,
    output logic               o_last
);

    t_qstat qstat;
    t_job   push_job;
    t_job   head_job;
    logic   push;
    logic   pop;

    vlt_front u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_start_z (i_start_z),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_end_z   (i_end_z),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_job     (push_job)
    );

    vlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    vlt_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cell_x (o_cell_x),
        .o_cell_y (o_cell_y),
        .o_cell_z (o_cell_z),
        .o_last   (o_last)
    );

endmodule

/* verif/voxel_line_traversal_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_line_traversal_top_tb
// Drives line requests from start to end voxel into the walker and checks every
// visited voxel and its last flag against an in-bench walk model. Directed rays
// cover extremes, single axes, planes and full diagonals. Random rays follow,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module voxel_line_traversal_top_tb;
    import vlt_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 3;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     MAX_REPORTS  = 20;
    localparam t_coord COORD_MAX    = t_coord'((1 << COORD_BITS) - 1);
    localparam longint TIMEOUT_NS   = 64'd50_000_000;

    typedef enum int {TRAFFIC_QUIET, TRAFFIC_MIXED, TRAFFIC_HEAVY} t_traffic;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
    } t_visit;

    class voxel_scoreboard;
        t_visit expected_visits[$];
        int     failures;
        int     requests;
        int     visits_checked;
        int     empty_runs;
        int     longest_run;

        // true when axis a reaches its next voxel boundary strictly before axis b
        static function bit crosses_first(input int unsigned ka, input int unsigned da,
                                          input int unsigned kb, input int unsigned db);
            if (da == 0) begin
                return 1'b0;
            end
            if (db == 0) begin
                return 1'b1;
            end
            return (2 * ka + 1) * db < (2 * kb + 1) * da;
        endfunction

        function void note_request(input t_coord sx, input t_coord sy, input t_coord sz,
                                   input t_coord ex, input t_coord ey, input t_coord ez);
            t_coord      here[3];
            t_coord      goal[3];
            int unsigned span[3];
            int unsigned taken[3];
            bit          go_up[3];
            bit          step_ax[3];
            bit          x_before_y;
            bit          y_before_x;
            bit          reached;
            t_visit      v;
            int          run_len;
            here    = '{sx, sy, sz};
            goal    = '{ex, ey, ez};
            run_len = 0;
            for (int a = 0; a < 3; a++) begin
                go_up[a] = here[a] < goal[a];
                span[a]  = go_up[a] ? goal[a] - here[a] : here[a] - goal[a];
                taken[a] = 0;
            end
            reached = (here[0] == goal[0]) && (here[1] == goal[1]) && (here[2] == goal[2]);
            while (!reached && run_len < MAX_STEPS) begin
                step_ax    = '{1'b0, 1'b0, 1'b0};
                x_before_y = crosses_first(taken[AX_X], span[AX_X], taken[AX_Y], span[AX_Y]);
                y_before_x = crosses_first(taken[AX_Y], span[AX_Y], taken[AX_X], span[AX_X]);
                if (x_before_y) begin
                    if (crosses_first(taken[AX_X], span[AX_X], taken[AX_Z], span[AX_Z]))
                        step_ax[AX_X] = 1'b1;
                    else
                        step_ax[AX_Z] = 1'b1;
                end else if (y_before_x) begin
                    if (crosses_first(taken[AX_Y], span[AX_Y], taken[AX_Z], span[AX_Z]))
                        step_ax[AX_Y] = 1'b1;
                    else
                        step_ax[AX_Z] = 1'b1;
                end else if (crosses_first(taken[AX_Y], span[AX_Y],
                                           taken[AX_Z], span[AX_Z])) begin
                    // x and y cross together ahead of z
                    step_ax[AX_X] = 1'b1;
                    step_ax[AX_Y] = 1'b1;
                end else begin
                    step_ax[AX_Z] = 1'b1;
                end
                for (int a = 0; a < 3; a++) begin
                    if (step_ax[a]) begin
                        here[a]  = go_up[a] ? here[a] + 1'b1 : here[a] - 1'b1;
                        taken[a] = taken[a] + 1;
                    end
                end
                reached = (here[0] == goal[0]) && (here[1] == goal[1]) && (here[2] == goal[2]);
                v.x    = here[AX_X];
                v.y    = here[AX_Y];
                v.z    = here[AX_Z];
                v.last = reached;
                expected_visits.push_back(v);
                run_len++;
            end
            requests++;
            if (run_len == 0) begin
                empty_runs++;
            end
            if (run_len > longest_run) begin
                longest_run = run_len;
            end
        endfunction

        function void check_visit(input t_coord x, input t_coord y, input t_coord z,
                                  input logic last);
            t_visit want;
            if (expected_visits.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: voxel (%0d,%0d,%0d) last %0b with no request pending",
                             $time, x, y, z, last);
                return;
            end
            want = expected_visits.pop_front();
            visits_checked++;
            if (want.x !== x || want.y !== y || want.z !== z || want.last !== last) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"%0t: voxel mismatch, expected (%0d,%0d,%0d) last %0b, ",
                              "got (%0d,%0d,%0d) last %0b"},
                             $time, want.x, want.y, want.z, want.last, x, y, z, last);
            end
        endfunction

        function int pending();
            return expected_visits.size();
        endfunction
    endclass

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   i_valid   = 1'b0;
    logic   o_ready;
    t_coord i_start_x = '0;
    t_coord i_start_y = '0;
    t_coord i_start_z = '0;
    t_coord i_end_x   = '0;
    t_coord i_end_y   = '0;
    t_coord i_end_z   = '0;
    logic   o_valid;
    logic   i_ready   = 1'b0;
    t_coord o_cell_x;
    t_coord o_cell_y;
    t_coord o_cell_z;
    logic   o_last;

    voxel_scoreboard score = new();
    t_traffic        traffic = TRAFFIC_MIXED;
    int              stall_left;
    int              rx_gap;

    voxel_line_traversal_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_start_z (i_start_z),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_end_z   (i_end_z),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cell_x  (o_cell_x),
        .o_cell_y  (o_cell_y),
        .o_cell_z  (o_cell_z),
        .o_last    (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input t_traffic mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == TRAFFIC_QUIET || r >= (mode == TRAFFIC_HEAVY ? 60 : 25)) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // voxel sink with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                score.check_visit(o_cell_x, o_cell_y, o_cell_z, o_last);
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else begin
                rx_gap = pick_gap(traffic);
                if (rx_gap > 0) begin
                    stall_left <= rx_gap - 1;
                    i_ready    <= 1'b0;
                end else begin
                    i_ready    <= 1'b1;
                end
            end
        end
    end

    task automatic send_request(input t_coord sx, input t_coord sy, input t_coord sz,
                                input t_coord ex, input t_coord ey, input t_coord ez);
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_start_z <= sz;
        i_end_x   <= ex;
        i_end_y   <= ey;
        i_end_z   <= ez;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        score.note_request(sx, sy, sz, ex, ey, ez);
    endtask

    task automatic issue_request(input t_coord sx, input t_coord sy, input t_coord sz,
                                 input t_coord ex, input t_coord ey, input t_coord ez);
        int gap;
        gap = pick_gap(traffic);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        send_request(sx, sy, sz, ex, ey, ez);
    endtask

    task automatic random_request();
        t_coord s[3];
        t_coord e[3];
        int     kind;
        int     near;
        int     ax;
        kind = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++) begin
            s[a] = t_coord'($urandom_range(0, COORD_MAX));
            e[a] = t_coord'($urandom_range(0, COORD_MAX));
        end
        if (kind < 45) begin
            // fully random ray
        end else if (kind < 70) begin
            // short ray in a small neighborhood
            for (int a = 0; a < 3; a++) begin
                near = int'(s[a]) + int'($urandom_range(0, 6)) - 3;
                if (near < 0) near = 0;
                if (near > COORD_MAX) near = COORD_MAX;
                e[a] = t_coord'(near);
            end
        end else if (kind < 85) begin
            // ray in a plane or along one axis
            ax    = $urandom_range(0, 2);
            e[ax] = s[ax];
            for (int a = 0; a < 3; a++) begin
                if ($urandom_range(0, 1) == 1) e[a] = s[a];
            end
        end else if (kind < 95) begin
            // grid corners
            for (int a = 0; a < 3; a++) begin
                s[a] = $urandom_range(0, 1) ? COORD_MAX : t_coord'(0);
                e[a] = $urandom_range(0, 1) ? COORD_MAX : t_coord'(0);
            end
        end else begin
            e = s;
        end
        issue_request(s[0], s[1], s[2], e[0], e[1], e[2]);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        traffic = TRAFFIC_MIXED;
        issue_request(4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5);
        issue_request(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        issue_request(4'd0, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0);
        issue_request(4'd15, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        issue_request(4'd0, 4'd0, 4'd0, 4'd0, 4'd15, 4'd0);
        issue_request(4'd0, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0);
        issue_request(4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 4'd0);
        issue_request(4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd0);
        issue_request(4'd0, 4'd0, 4'd0, 4'd15, 4'd0, 4'd15);
        issue_request(4'd0, 4'd0, 4'd0, 4'd0, 4'd15, 4'd15);
        issue_request(4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15);
        issue_request(4'd15, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0);
        issue_request(4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15);
        issue_request(4'd0, 4'd0, 4'd0, 4'd15, 4'd14, 4'd13);
        issue_request(4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0);
        issue_request(4'd0, 4'd0, 4'd0, 4'd15, 4'd7, 4'd3);
        issue_request(4'd3, 4'd9, 4'd12, 4'd12, 4'd2, 4'd5);
        issue_request(4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8);
        issue_request(4'd7, 4'd7, 4'd7, 4'd6, 4'd8, 4'd7);
        issue_request(4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd8);
        issue_request(4'd0, 4'd0, 4'd0, 4'd1, 4'd15, 4'd0);
        issue_request(4'd10, 4'd5, 4'd0, 4'd0, 4'd0, 4'd10);

        traffic = TRAFFIC_QUIET;
        repeat (70) random_request();
        traffic = TRAFFIC_MIXED;
        repeat (140) random_request();
        traffic = TRAFFIC_HEAVY;
        repeat (140) random_request();
        i_valid <= 1'b0;

        traffic = TRAFFIC_MIXED;
        while (score.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("walked %0d line requests (%0d with start at the end), %0d voxels compared",
                 score.requests, score.empty_runs, score.visits_checked);
        $display("longest run %0d voxels, %0d errors", score.longest_run, score.failures);
        if (score.failures == 0 && score.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d voxels outstanding", $time, score.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hdl/vlt_pkg.sv
hdl/vlt_front.sv
hdl/vlt_queue.sv
hdl/vlt_walk.sv
hdl/voxel_line_traversal_top.sv
verif/voxel_line_traversal_top_tb.sv
